@@ hw/rtl/erfc_pkg.sv @@
// Shared constants and elaboration-time helpers for the erfc approximation core.
package erfc_pkg;

  localparam int unsigned OUT_FRAC_BITS_DEF = 16;
  localparam int unsigned ARG_W             = 17;
  localparam int unsigned MAG_W             = 17;
  localparam int unsigned Q                 = 31;
  localparam int unsigned DIV_BITS          = 32;
  localparam int unsigned HORNER_STEPS      = 5;
  localparam int unsigned TAYLOR_TERMS      = 24;
  localparam int unsigned POW_STEPS         = 32;

  localparam logic [63:0] DEC_SCALE = 64'd1000000000;
  localparam logic [63:0] DEC_HALF  = 64'd500000000;

  localparam logic [63:0] KP_WIDE = (64'd327591100 * (64'd1 << 32) + DEC_HALF) / DEC_SCALE;
  localparam logic [30:0] KP      = KP_WIDE[30:0];

  localparam logic [63:0] A5_MAG = (64'd1061405429 * (64'd1 << Q) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] A4_MAG = (64'd1453152027 * (64'd1 << Q) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] A3_MAG = (64'd1421413741 * (64'd1 << Q) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] A2_MAG = (64'd284496736 * (64'd1 << Q) + DEC_HALF) / DEC_SCALE;
  localparam logic [63:0] A1_MAG = (64'd254829592 * (64'd1 << Q) + DEC_HALF) / DEC_SCALE;

  localparam logic signed [33:0] A5 = $signed(A5_MAG[33:0]);

  // Coefficient added after each Horner multiplication; the last step adds nothing.
  function automatic logic signed [33:0] horner_coef(input int unsigned idx);
    logic signed [33:0] c;
    case (idx)
      0:       c = -$signed(A4_MAG[33:0]);
      1:       c = $signed(A3_MAG[33:0]);
      2:       c = -$signed(A2_MAG[33:0]);
      3:       c = $signed(A1_MAG[33:0]);
      default: c = '0;
    endcase
    return c;
  endfunction

  // exp(-1) in Q.31, built with the same rounded series as the datapath.
  function automatic logic [30:0] exp_neg_one_q31();
    logic [63:0] term;
    longint      sum;
    term = 64'd1 << Q;
    sum  = longint'(64'd1 << Q);
    for (int unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (term * (64'd1 << Q) + (64'd1 << (Q - 1))) >> Q;
      term = (term + 64'(n / 2)) / 64'(n);
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 31'(sum);
  endfunction

  localparam logic [30:0] EM1 = exp_neg_one_q31();

endpackage

@@ hw/rtl/erfc_rational_approx_core.sv @@
// Pipelined complementary error function of a Q4.13 argument, result in unsigned fixed point.
// The pipeline depth is set by the 32-stage restoring divider for t, the Horner stages,
// the 24 Taylor terms of three stages each and the 32-step exp(-1) power chain.
// Throughput: one beat per cycle while the output is not stalled.
// A stall on the output freezes every stage. Reset clears only the valid bits.
module erfc_rational_approx_core #(
  parameter int unsigned OutFracBits = erfc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [erfc_pkg::ARG_W-1:0]   arg_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic        [OutFracBits+1:0]       value_o
);

  localparam int unsigned HrnStages = 2 * erfc_pkg::HORNER_STEPS;
  localparam int unsigned TayStages = 3 * erfc_pkg::TAYLOR_TERMS;
  localparam int unsigned Depth     = 2 + (erfc_pkg::DIV_BITS + 1) + (HrnStages + 1)
                                      + (TayStages + 1) + (erfc_pkg::POW_STEPS + 1) + 2;
  localparam int unsigned Sh        = 2 * erfc_pkg::Q - OutFracBits;
  localparam int unsigned YW        = OutFracBits + 3;

  typedef struct packed {
    logic [33:0] den;
    logic [33:0] rem;
    logic [31:0] nlo;
    logic [31:0] quo;
    logic [30:0] frac;
    logic [6:0]  ipart;
    logic        neg;
  } div_t;

  typedef struct packed {
    logic [31:0]        t;
    logic signed [33:0] z;
    logic [63:0]        prod;
    logic               zneg;
    logic [30:0]        frac;
    logic [6:0]         ipart;
    logic               neg;
  } hrn_t;

  typedef struct packed {
    logic [31:0]        term;
    logic [62:0]        pm;
    logic [65:0]        pr;
    logic signed [33:0] sum;
    logic [31:0]        zc;
    logic [30:0]        frac;
    logic [6:0]         ipart;
    logic               neg;
  } tay_t;

  typedef struct packed {
    logic [31:0] e;
    logic [31:0] zc;
    logic [6:0]  ipart;
    logic        neg;
  } pow_t;

  logic                           en;
  logic [Depth-1:0]               valid_q;
  logic                           neg0_q;
  logic [erfc_pkg::MAG_W-1:0]     mag0_q;
  logic [erfc_pkg::MAG_W-1:0]     mag_in;
  logic                           neg1_q;
  logic [32:0]                    sq1_q;
  logic [47:0]                    pk1_q;
  logic [33:0]                    sq_full;
  logic [47:0]                    pk_full;
  logic [48:0]                    pk_rnd;
  logic [35:0]                    den_sum;
  logic [33:0]                    den_c;
  div_t                           div0_d;
  div_t                           div_q [0:erfc_pkg::DIV_BITS];
  hrn_t                           hrn0_d;
  hrn_t                           hrn_q [0:HrnStages];
  tay_t                           tay0_d;
  tay_t                           tay_q [0:TayStages];
  pow_t                           pow0_d;
  pow_t                           pow_q [0:erfc_pkg::POW_STEPS];
  logic [63:0]                    fprod_q;
  logic                           fneg_q;
  logic [64:0]                    ysum;
  logic [YW-1:0]                  y_raw;
  logic [YW-1:0]                  y_cl;
  logic [YW-1:0]                  y_res;
  logic [YW-1:0]                  full2;
  logic [OutFracBits+1:0]         value_d;
  logic [OutFracBits+1:0]         value_q;

  assign en          = ~valid_q[Depth-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[Depth-1];
  assign value_o     = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Depth-2:0], in_valid_i};
    end
  end

  // Magnitude and sign of the argument; the most negative code gives 8.0 exactly.
  assign mag_in  = arg_i[erfc_pkg::ARG_W-1] ? erfc_pkg::MAG_W'(17'd0 - $unsigned(arg_i))
                                            : erfc_pkg::MAG_W'($unsigned(arg_i));
  assign sq_full = 34'(mag0_q) * 34'(mag0_q);
  assign pk_full = 48'(erfc_pkg::KP) * 48'(mag0_q);
  assign pk_rnd  = 49'(pk1_q) + 49'd4096;
  assign den_sum = 36'(pk_rnd >> 13) + (36'd1 << 32);
  assign den_c   = den_sum[33:0];

  always_comb begin
    div0_d       = '0;
    div0_d.den   = den_c;
    div0_d.rem   = {2'b00, 1'b1, 30'd0, den_c[33]};
    div0_d.nlo   = den_c[32:1];
    div0_d.frac  = {sq1_q[25:0], 5'd0};
    div0_d.ipart = sq1_q[32:26];
    div0_d.neg   = neg1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg0_q   <= arg_i[erfc_pkg::ARG_W-1];
      mag0_q   <= mag_in;
      neg1_q   <= neg0_q;
      sq1_q    <= sq_full[32:0];
      pk1_q    <= pk_full;
      div_q[0] <= div0_d;
    end
  end

  for (genvar i = 1; i <= erfc_pkg::DIV_BITS; i++) begin : g_div
    localparam int unsigned B = erfc_pkg::DIV_BITS - i;
    logic [34:0] trial;
    logic        ge;
    div_t        div_d;
    always_comb begin
      trial       = {div_q[i-1].rem, div_q[i-1].nlo[B]};
      ge          = trial >= {1'b0, div_q[i-1].den};
      div_d       = div_q[i-1];
      div_d.quo[B] = ge;
      div_d.rem   = ge ? 34'(trial - {1'b0, div_q[i-1].den}) : trial[33:0];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[i] <= div_d;
      end
    end
  end

  always_comb begin
    hrn0_d       = '0;
    hrn0_d.t     = div_q[erfc_pkg::DIV_BITS].quo;
    hrn0_d.z     = erfc_pkg::A5;
    hrn0_d.frac  = div_q[erfc_pkg::DIV_BITS].frac;
    hrn0_d.ipart = div_q[erfc_pkg::DIV_BITS].ipart;
    hrn0_d.neg   = div_q[erfc_pkg::DIV_BITS].neg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hrn_q[0] <= hrn0_d;
    end
  end

  for (genvar j = 0; j < erfc_pkg::HORNER_STEPS; j++) begin : g_hrn
    logic [32:0]        zmag;
    logic [64:0]        pfull;
    logic [63:0]        rsum;
    logic signed [33:0] zterm;
    hrn_t               mul_d;
    hrn_t               add_d;
    always_comb begin
      zmag       = hrn_q[2*j].z[33] ? 33'(-hrn_q[2*j].z) : 33'(hrn_q[2*j].z);
      pfull      = 65'(zmag) * 65'(hrn_q[2*j].t);
      mul_d      = hrn_q[2*j];
      mul_d.prod = pfull[63:0];
      mul_d.zneg = hrn_q[2*j].z[33];
    end
    always_comb begin
      rsum    = hrn_q[2*j+1].prod + (64'd1 << (erfc_pkg::Q - 1));
      zterm   = hrn_q[2*j+1].zneg ? -$signed({1'b0, rsum[63:31]})
                                  : $signed({1'b0, rsum[63:31]});
      add_d   = hrn_q[2*j+1];
      add_d.z = erfc_pkg::horner_coef(j) + zterm;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        hrn_q[2*j+1] <= mul_d;
        hrn_q[2*j+2] <= add_d;
      end
    end
  end

  always_comb begin
    tay0_d       = '0;
    tay0_d.term  = 32'd1 << erfc_pkg::Q;
    tay0_d.sum   = 34'sd1 <<< erfc_pkg::Q;
    tay0_d.zc    = hrn_q[HrnStages].z[33] ? 32'd0 : hrn_q[HrnStages].z[31:0];
    tay0_d.frac  = hrn_q[HrnStages].frac;
    tay0_d.ipart = hrn_q[HrnStages].ipart;
    tay0_d.neg   = hrn_q[HrnStages].neg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tay_q[0] <= tay0_d;
    end
  end

  for (genvar n = 1; n <= erfc_pkg::TAYLOR_TERMS; n++) begin : g_tay
    localparam int unsigned N     = n;
    localparam int unsigned K     = 32 + $clog2(N);
    localparam logic [65:0] M     = 66'((64'd1 << K) / 64'(N) + 64'd1);
    localparam logic [31:0] HalfN = 32'(N / 2);
    localparam int unsigned S0    = 3 * (n - 1);
    logic [63:0] rsum;
    logic [31:0] xq;
    logic [31:0] qt;
    tay_t        mul_d;
    tay_t        div_d;
    tay_t        acc_d;
    always_comb begin
      mul_d    = tay_q[S0];
      mul_d.pm = 63'(tay_q[S0].term) * 63'(tay_q[S0].frac);
    end
    always_comb begin
      rsum     = {1'b0, tay_q[S0+1].pm} + (64'd1 << (erfc_pkg::Q - 1));
      xq       = 32'(rsum[63:31]) + HalfN;
      div_d    = tay_q[S0+1];
      div_d.pr = 66'(xq) * M;
    end
    always_comb begin
      qt         = 32'(tay_q[S0+2].pr >> K);
      acc_d      = tay_q[S0+2];
      acc_d.term = qt;
      acc_d.sum  = N[0] ? tay_q[S0+2].sum - $signed({2'b00, qt})
                        : tay_q[S0+2].sum + $signed({2'b00, qt});
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        tay_q[S0+1] <= mul_d;
        tay_q[S0+2] <= div_d;
        tay_q[S0+3] <= acc_d;
      end
    end
  end

  always_comb begin
    pow0_d       = '0;
    pow0_d.e     = tay_q[TayStages].sum[33] ? 32'd0 : tay_q[TayStages].sum[31:0];
    pow0_d.zc    = tay_q[TayStages].zc;
    pow0_d.ipart = tay_q[TayStages].ipart;
    pow0_d.neg   = tay_q[TayStages].neg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pow_q[0] <= pow0_d;
    end
  end

  // One factor of exp(-1) per stage while the integer part of x*x allows it.
  for (genvar k = 1; k <= erfc_pkg::POW_STEPS; k++) begin : g_pow
    logic [62:0] pp;
    logic [62:0] prnd;
    pow_t        pow_d;
    always_comb begin
      pp    = 63'(pow_q[k-1].e) * 63'(erfc_pkg::EM1);
      prnd  = pp + (63'd1 << (erfc_pkg::Q - 1));
      pow_d = pow_q[k-1];
      if (7'(k - 1) < pow_q[k-1].ipart) begin
        pow_d.e = 32'(prnd >> erfc_pkg::Q);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        pow_q[k] <= pow_d;
      end
    end
  end

  assign ysum  = 65'(fprod_q) + (65'd1 << (Sh - 1));
  assign y_raw = YW'(ysum >> Sh);
  assign full2 = YW'(1) << (OutFracBits + 1);
  assign y_cl  = (y_raw > full2) ? full2 : y_raw;
  assign y_res = fneg_q ? (full2 - y_cl) : y_cl;
  assign value_d = y_res[OutFracBits+1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fprod_q <= 64'(pow_q[erfc_pkg::POW_STEPS].zc) * 64'(pow_q[erfc_pkg::POW_STEPS].e);
      fneg_q  <= pow_q[erfc_pkg::POW_STEPS].neg;
      value_q <= value_d;
    end
  end

endmodule

@@ hw/rtl/erfc_checker.sv @@
// Port-level assertions for the erfc approximation core and their bind.
module erfc_checker #(
  parameter int unsigned OutFracBits = erfc_pkg::OUT_FRAC_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [OutFracBits+1:0]        value_o
);

  localparam logic [OutFracBits+1:0] Two = (OutFracBits + 2)'(1) << (OutFracBits + 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output beat dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(value_o))
    else $error("Output value changed during a stall.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> value_o <= Two)
    else $error("Output value exceeds two.");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("Input stalled while the output was empty.");

endmodule

bind erfc_rational_approx_core erfc_checker #(.OutFracBits(OutFracBits)) u_erfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_o     (value_o)
);
